>>> rtl/core/kvl_pkg.sv
package kvl_pkg;

  localparam int KC_W = 7;
  localparam int PC_W = 4;
  localparam int DIV_STEPS = 16;
  localparam int FRAC_W = 16;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] STATUS_INTERP = 2'd0;
  localparam logic [1:0] STATUS_SINGLE = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         key_index;
    logic [31:0]        time_value;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        time_v;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } key_row_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_START,
    OP_SEARCH,
    OP_LOAD_A,
    OP_LOAD_D,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL
  } dp_op_t;

  typedef enum logic [1:0] {
    CMP_X,
    CMP_Y,
    CMP_Z
  } comp_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_X,
    ACC_Y,
    ACC_Z,
    ACC_ZERO,
    ACC_ROW
  } acc_t;

  typedef enum logic {
    AD_SEG,
    AD_SEG1
  } addr_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_SAMPLE,
    C_EMPTY,
    C_SINGLE,
    C_MISS,
    C_CNT_NZ
  } cond_t;

  typedef struct packed {
    dp_op_t            op;
    comp_t             comp;
    acc_t              acc;
    addr_t             addr;
    logic              emit;
    logic [1:0]        status;
    cond_t             cond;
    logic [PC_W-1:0]   target;
  } ucw_t;

  typedef struct packed {
    logic empty;
    logic single;
    logic miss;
    logic cnt_nz;
  } dp_flags_t;

  // program steps
  localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] ST_CHK0   = 4'd1;
  localparam logic [PC_W-1:0] ST_CHK1   = 4'd2;
  localparam logic [PC_W-1:0] ST_SRD    = 4'd3;
  localparam logic [PC_W-1:0] ST_SCMP   = 4'd4;
  localparam logic [PC_W-1:0] ST_RDA    = 4'd5;
  localparam logic [PC_W-1:0] ST_LDA    = 4'd6;
  localparam logic [PC_W-1:0] ST_LDD    = 4'd7;
  localparam logic [PC_W-1:0] ST_DINIT  = 4'd8;
  localparam logic [PC_W-1:0] ST_DSTEP  = 4'd9;
  localparam logic [PC_W-1:0] ST_MX     = 4'd10;
  localparam logic [PC_W-1:0] ST_MY     = 4'd11;
  localparam logic [PC_W-1:0] ST_MZ     = 4'd12;
  localparam logic [PC_W-1:0] ST_FIN    = 4'd13;
  localparam logic [PC_W-1:0] ST_EMPTY  = 4'd14;
  localparam logic [PC_W-1:0] ST_SINGLE = 4'd15;

  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    w.op     = OP_NOP;
    w.comp   = CMP_X;
    w.acc    = ACC_NONE;
    w.addr   = AD_SEG;
    w.emit   = 1'b0;
    w.status = STATUS_INTERP;
    w.cond   = C_NEVER;
    w.target = ST_IDLE;
    unique case (pc)
      ST_IDLE: begin
        w.op     = OP_START;
        w.cond   = C_NO_SAMPLE;
        w.target = ST_IDLE;
      end
      ST_CHK0: begin
        w.cond   = C_EMPTY;
        w.target = ST_EMPTY;
      end
      ST_CHK1: begin
        // row 0 is fetched here in case the table holds a single key
        w.addr   = AD_SEG;
        w.cond   = C_SINGLE;
        w.target = ST_SINGLE;
      end
      ST_SRD: begin
        w.addr = AD_SEG1;
      end
      ST_SCMP: begin
        w.op     = OP_SEARCH;
        w.cond   = C_MISS;
        w.target = ST_SRD;
      end
      ST_RDA: begin
        w.addr = AD_SEG;
      end
      ST_LDA: begin
        w.op   = OP_LOAD_A;
        w.addr = AD_SEG1;
      end
      ST_LDD: begin
        w.op = OP_LOAD_D;
      end
      ST_DINIT: begin
        w.op = OP_DIV_INIT;
      end
      ST_DSTEP: begin
        w.op     = OP_DIV_STEP;
        w.cond   = C_CNT_NZ;
        w.target = ST_DSTEP;
      end
      ST_MX: begin
        w.op   = OP_MUL;
        w.comp = CMP_X;
      end
      ST_MY: begin
        w.op   = OP_MUL;
        w.comp = CMP_Y;
        w.acc  = ACC_X;
      end
      ST_MZ: begin
        w.op   = OP_MUL;
        w.comp = CMP_Z;
        w.acc  = ACC_Y;
      end
      ST_FIN: begin
        w.acc    = ACC_Z;
        w.emit   = 1'b1;
        w.status = STATUS_INTERP;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_EMPTY: begin
        w.acc    = ACC_ZERO;
        w.emit   = 1'b1;
        w.status = STATUS_EMPTY;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_SINGLE: begin
        w.acc    = ACC_ROW;
        w.emit   = 1'b1;
        w.status = STATUS_SINGLE;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/kvl_keymem.sv
module kvl_keymem #(
  parameter int MAX_KEYS = 64,
  parameter int AW = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  kvl_pkg::key_row_t wr_row,
  input  logic [AW-1:0]     rd_addr,
  output kvl_pkg::key_row_t rd_row
);
  import kvl_pkg::*;

  key_row_t key_mem_r [MAX_KEYS];
  key_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr] <= wr_row;
    end
    rd_row_r <= key_mem_r[rd_addr];
  end

  assign rd_row = rd_row_r;

endmodule

>>> rtl/core/kvl_seq.sv
module kvl_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sample_req,
  input  kvl_pkg::dp_flags_t flags,
  output kvl_pkg::ucw_t      ctrl,
  output logic               busy
);
  import kvl_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = ucode_rom(pc_r);
  assign busy = (pc_r != ST_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_SAMPLE: take = !sample_req;
      C_EMPTY:     take = flags.empty;
      C_SINGLE:    take = flags.single;
      C_MISS:      take = flags.miss;
      C_CNT_NZ:    take = flags.cnt_nz;
      default:     take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/core/kvl_dpath.sv
module kvl_dpath #(
  parameter int MAX_KEYS = 64,
  parameter int AW = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kvl_pkg::ucw_t      ctrl,
  input  logic [kvl_pkg::KC_W-1:0] key_count,
  input  logic [31:0]        sample_time,
  input  kvl_pkg::key_row_t  rd_row,
  output logic [AW-1:0]      rd_addr,
  output kvl_pkg::dp_flags_t flags,
  output logic               out_valid,
  output kvl_pkg::out_word_t out_data
);
  import kvl_pkg::*;

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int SW = AW + 1;
  localparam int FW = FRAC_W + 1;
  localparam int PW = 33 + FW + 1;
  localparam int DCW = $clog2(DIV_STEPS);

  logic [31:0]        kc32;
  logic [31:0]        n32;
  logic [CW-1:0]      n;
  logic               hit;

  logic [31:0]        t_r, t_nxt;
  logic [AW-1:0]      seg_r, seg_nxt;
  logic [31:0]        t0_r, t0_nxt;
  logic signed [31:0] a_x_r, a_x_nxt, a_y_r, a_y_nxt, a_z_r, a_z_nxt;
  logic signed [32:0] d_x_r, d_x_nxt, d_y_r, d_y_nxt, d_z_r, d_z_nxt;
  logic [31:0]        num_r, num_nxt, den_r, den_nxt;
  logic               zero_r, zero_nxt, one_r, one_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [32:0]        rem_sh;
  logic [FRAC_W-1:0]  q_r, q_nxt;
  logic [DCW-1:0]     cnt_r, cnt_nxt;
  logic [FW-1:0]      factor;
  logic signed [FW:0] fac_s;
  logic signed [32:0] d_sel;
  logic signed [PW-1:0] prod_r, prod_nxt, prod_sh;
  logic signed [31:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               valid_r;

  // clamp the count to the table depth
  assign kc32 = 32'(key_count);
  assign n32  = (kc32 > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : kc32;
  assign n    = n32[CW-1:0];

  // stop at the first later key, or at the last segment
  assign hit = (t_r < rd_row.time_v) || ((SW'(seg_r) + SW'(2)) >= SW'(n));

  assign flags.empty  = (n == CW'(0));
  assign flags.single = (n == CW'(1));
  assign flags.miss   = !hit;
  assign flags.cnt_nz = (cnt_r != DCW'(0));

  assign rd_addr = (ctrl.addr == AD_SEG1) ? seg_r + AW'(1) : seg_r;

  assign factor = zero_r ? FW'(0) : (one_r ? FW'(1 << FRAC_W) : FW'(q_r));
  assign fac_s  = $signed({1'b0, factor});
  assign rem_sh = {rem_r, 1'b0};
  assign prod_sh = prod_r >>> FRAC_W;

  always_comb begin
    unique case (ctrl.comp)
      CMP_X:   d_sel = d_x_r;
      CMP_Y:   d_sel = d_y_r;
      CMP_Z:   d_sel = d_z_r;
      default: d_sel = d_x_r;
    endcase
  end

  always_comb begin
    t_nxt    = t_r;
    seg_nxt  = seg_r;
    t0_nxt   = t0_r;
    a_x_nxt  = a_x_r;
    a_y_nxt  = a_y_r;
    a_z_nxt  = a_z_r;
    d_x_nxt  = d_x_r;
    d_y_nxt  = d_y_r;
    d_z_nxt  = d_z_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    zero_nxt = zero_r;
    one_nxt  = one_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_START: begin
        t_nxt   = sample_time;
        seg_nxt = '0;
      end
      OP_SEARCH: begin
        if (!hit) begin
          seg_nxt = seg_r + AW'(1);
        end
      end
      OP_LOAD_A: begin
        t0_nxt  = rd_row.time_v;
        a_x_nxt = rd_row.x;
        a_y_nxt = rd_row.y;
        a_z_nxt = rd_row.z;
      end
      OP_LOAD_D: begin
        d_x_nxt  = 33'(rd_row.x) - 33'(a_x_r);
        d_y_nxt  = 33'(rd_row.y) - 33'(a_y_r);
        d_z_nxt  = 33'(rd_row.z) - 33'(a_z_r);
        num_nxt  = t_r - t0_r;
        den_nxt  = rd_row.time_v - t0_r;
        zero_nxt = (rd_row.time_v <= t0_r) || (t_r <= t0_r);
      end
      OP_DIV_INIT: begin
        one_nxt = (num_r >= den_r);
        rem_nxt = num_r;
        q_nxt   = '0;
        cnt_nxt = DCW'(DIV_STEPS - 1);
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per step
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = 32'(rem_sh - {1'b0, den_r});
          q_nxt   = {q_r[FRAC_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          q_nxt   = {q_r[FRAC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - DCW'(1);
      end
      OP_MUL: begin
        prod_nxt = PW'(d_sel) * PW'(fac_s);
      end
    endcase
  end

  always_comb begin
    out_x_nxt  = out_x_r;
    out_y_nxt  = out_y_r;
    out_z_nxt  = out_z_r;
    status_nxt = ctrl.emit ? ctrl.status : status_r;
    unique case (ctrl.acc)
      ACC_NONE: begin
      end
      ACC_X:    out_x_nxt = a_x_r + $signed(prod_sh[31:0]);
      ACC_Y:    out_y_nxt = a_y_r + $signed(prod_sh[31:0]);
      ACC_Z:    out_z_nxt = a_z_r + $signed(prod_sh[31:0]);
      ACC_ZERO: begin
        out_x_nxt = '0;
        out_y_nxt = '0;
        out_z_nxt = '0;
      end
      ACC_ROW: begin
        out_x_nxt = rd_row.x;
        out_y_nxt = rd_row.y;
        out_z_nxt = rd_row.z;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    seg_r    <= seg_nxt;
    t0_r     <= t0_nxt;
    a_x_r    <= a_x_nxt;
    a_y_r    <= a_y_nxt;
    a_z_r    <= a_z_nxt;
    d_x_r    <= d_x_nxt;
    d_y_r    <= d_y_nxt;
    d_z_r    <= d_z_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    zero_r   <= zero_nxt;
    one_r    <= one_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    prod_r   <= prod_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_z_r  <= out_z_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= ctrl.emit;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_data.out_x  = out_x_r;
  assign out_data.out_y  = out_y_r;
  assign out_data.out_z  = out_z_r;
  assign out_data.status = status_r;

endmodule

>>> rtl/core/keyframe_vector_lerp.sv
// keyframe table with linear blend between timed 3d keys
//
// input word: taken when start is high and busy is low. cmd selects a key
// write (key_index, time_value, value_x/y/z) or a sample at time_value.
// a write stores the key in the same cycle, raises no busy and gives no
// result word; the next word may follow in the next cycle.
// a sample raises busy until its result word has been built. the result
// word shows on out_data for one cycle with out_valid high; the receiver
// cannot hold it off, and busy drops in that same cycle.
// with n keys, the key search reads k of them (k from 1 to n-1), one
// after another through the single read port of the key memory, and
// compares each before it reads the next; the blend factor takes a 16
// step restoring divider.
// cfg: one write word sets key_count, taken whenever busy is low.
// reset clears the sequencer, the output strobe and key_count; the key
// memory is not cleared and holds garbage until written.
module keyframe_vector_lerp #(
  parameter int MAX_KEYS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  kvl_pkg::in_word_t           in_data,
  output logic                        out_valid,
  output kvl_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kvl_pkg::KC_W-1:0]    cfg_data
);
  import kvl_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);

  logic [KC_W-1:0] key_count_r;
  logic            wr_en;
  logic            in_range;
  logic            sample_req;
  key_row_t        wr_row;
  key_row_t        rd_row;
  logic [AW-1:0]   rd_addr;
  ucw_t            ctrl;
  dp_flags_t       flags;

  // key_count register, written only between samples
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_count_r <= cfg_data;
    end
  end

  // key writes go straight into the memory; slots past the depth are dropped
  assign in_range   = (32'(in_data.key_index) < 32'(MAX_KEYS));
  assign wr_en      = start && !busy && (in_data.cmd == CMD_WRITE) && in_range;
  assign sample_req = start && (in_data.cmd == CMD_SAMPLE);

  assign wr_row.time_v = in_data.time_value;
  assign wr_row.x      = in_data.value_x;
  assign wr_row.y      = in_data.value_y;
  assign wr_row.z      = in_data.value_z;

  // microcode sequencer: step counter plus control rom
  kvl_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample_req (sample_req),
    .flags      (flags),
    .ctrl       (ctrl),
    .busy       (busy)
  );

  // key table, one row per key, registered read
  kvl_keymem #(
    .MAX_KEYS (MAX_KEYS),
    .AW       (AW)
  ) u_keymem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.key_index)),
    .wr_row  (wr_row),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  // search, divider, shared multiplier and result registers
  kvl_dpath #(
    .MAX_KEYS (MAX_KEYS),
    .AW       (AW)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .key_count   (key_count_r),
    .sample_time (in_data.time_value),
    .rd_row      (rd_row),
    .rd_addr     (rd_addr),
    .flags       (flags),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
